### src/window_peak_normalize_quantize_core_macros.svh
// assertion helpers for the window normalize core
`ifndef WINDOW_PEAK_NORMALIZE_QUANTIZE_CORE_MACROS_SVH
`define WINDOW_PEAK_NORMALIZE_QUANTIZE_CORE_MACROS_SVH

// checked only while out of reset
`define WPNQ_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define WPNQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/wpnq_pkg.sv
`default_nettype none

package wpnq_pkg;

  // result format
  localparam int unsigned Q_WIDTH      = 17;
  localparam int unsigned FRAC_BITS    = 15;
  localparam int unsigned MAX_RES_BITS = 16;
  localparam int unsigned RES_W        = 5;
  localparam int unsigned EXP_W        = 4;
  localparam int unsigned SHIFT_W      = 4;

  // register port
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RESOLUTION = 2'd0
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_FILL,
    S_READ,
    S_START_I,
    S_WAIT_I,
    S_START_Q,
    S_WAIT_Q,
    S_SEND
  } state_e;

endpackage

`default_nettype wire

### src/wpnq_div.sv
`default_nettype none

// serial restoring divider: floor(x * 2^exp / peak), one quotient bit per cycle
module wpnq_div import wpnq_pkg::*; #(
  parameter int unsigned SW = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic signed [SW-1:0] x_i,
  input  wire logic        [SW-1:0] peak_i,
  input  wire logic     [EXP_W-1:0] exp_i,
  output logic                      done_o,
  output logic signed [Q_WIDTH-1:0] quot_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [EXP_W:0]       step_q;
  logic [SW:0]          rem_q;
  logic [SW-1:0]        den_q;
  logic [Q_WIDTH-2:0]   quo_q;
  logic                 neg_q;
  logic                 zero_q;

  logic [SW-1:0]        x_mag;
  logic                 bit_ge;
  logic [SW:0]          rem_next;
  logic [Q_WIDTH-1:0]   mag_up;

  assign x_mag    = x_i[SW-1] ? (~x_i + SW'(1)) : x_i;
  assign bit_ge   = rem_q >= {1'b0, den_q};
  assign rem_next = bit_ge ? (rem_q - {1'b0, den_q}) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= {1'b0, exp_i} + (EXP_W+1)'(1);
    end else if (busy_q) begin
      step_q <= step_q - (EXP_W+1)'(1);
      if (step_q == (EXP_W+1)'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, x_mag};
      den_q  <= peak_i;
      quo_q  <= '0;
      neg_q  <= x_i[SW-1];
      zero_q <= (peak_i == '0);
    end else if (busy_q) begin
      // remainder stays below the divisor, so doubling fits
      rem_q <= {rem_next[SW-1:0], 1'b0};
      quo_q <= {quo_q[Q_WIDTH-3:0], bit_ge};
    end
  end

  // negative operands round toward minus infinity
  assign mag_up = {1'b0, quo_q} + Q_WIDTH'(neg_q && (rem_q != '0));

  always_comb begin
    if (zero_q) begin
      quot_o = '0;
    end else if (neg_q) begin
      quot_o = -$signed(mag_up);
    end else begin
      quot_o = $signed(mag_up);
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

### src/window_peak_normalize_quantize_core.sv
// after the closing sample, per result: a store read, then I then Q on the shared serial
// divider, one quotient bit a cycle, then the send, which output stall can hold; the next
// result waits for the send; throughput: one sample per cycle while a window fills;
// resolution in bits is 1..16, larger acts as 16, 0 gives 16
// reset: async active low; clears sequencer, count, peak and resolution, store is not cleared
`default_nettype none

`include "window_peak_normalize_quantize_core_macros.svh"

module window_peak_normalize_quantize_core import wpnq_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 64,
  parameter int unsigned SAMPLE_WIDTH = 24,
  localparam int unsigned SW    = SAMPLE_WIDTH,
  localparam int unsigned IN_W  = ((2 * SW + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * Q_WIDTH + SW + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // sample stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_W-1:0]       s_axis_tdata,  // in_i, in_q, zero pad
  input  wire logic                  s_axis_tlast,  // in_last
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_W-1:0]           m_axis_tdata,  // out_i, out_q, full_scale, zero pad
  output logic                       m_axis_tlast,  // out_last
  // register port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);

  state_e                state_q, state_d;
  logic [CW-1:0]         cnt_q;
  logic [AW-1:0]         idx_q;
  logic [SW-1:0]         peak_q;
  logic [RES_W-1:0]      adc_q;
  logic signed [Q_WIDTH-1:0] out_i_q;
  logic signed [Q_WIDTH-1:0] out_q_q;

  // sample store, one I/Q pair per entry
  logic [2*SW-1:0]       window_mem [WINDOW_DEPTH];
  logic [2*SW-1:0]       rd_data_q;

  logic                  s_req;
  logic                  m_req;
  logic                  win_full;
  logic                  win_close;
  logic                  last_res;
  logic                  mem_wr;
  logic                  mem_rd;
  logic                  div_start;
  logic                  div_done;
  logic signed [Q_WIDTH-1:0] div_quot;
  logic signed [SW-1:0]  div_x;
  logic signed [SW-1:0]  in_i;
  logic signed [SW-1:0]  in_q;
  logic [SW-1:0]         mag_i;
  logic [SW-1:0]         mag_q;
  logic [SW-1:0]         peak_in;
  logic [RES_W-1:0]      bits_eff;
  logic [EXP_W-1:0]      div_exp;
  logic [SHIFT_W-1:0]    out_shift;
  logic                  reg_wr;

  // ---------------------------------------------------------------- register port
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready &&
                  (paddr[APB_ADDR_W-1:2] == REG_RESOLUTION);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adc_q <= '0;
    end else if (reg_wr) begin
      adc_q <= pwdata[RES_W-1:0];
    end
  end

  assign prdata = (paddr[APB_ADDR_W-1:2] == REG_RESOLUTION) ? APB_DATA_W'(adc_q) : '0;

  // resolution above sixteen acts as sixteen; zero means full Q1.15 normalization
  assign bits_eff = (adc_q > RES_W'(MAX_RES_BITS)) ? RES_W'(MAX_RES_BITS) : adc_q;

  always_comb begin
    if (bits_eff == '0) begin
      div_exp   = EXP_W'(FRAC_BITS);
      out_shift = '0;
    end else begin
      div_exp   = EXP_W'(bits_eff - RES_W'(1));
      out_shift = SHIFT_W'(RES_W'(MAX_RES_BITS) - bits_eff);
    end
  end

  // ---------------------------------------------------------------- input side
  assign in_i  = s_axis_tdata[SW-1:0];
  assign in_q  = s_axis_tdata[2*SW-1:SW];
  assign mag_i = in_i[SW-1] ? (~in_i + SW'(1)) : in_i;
  assign mag_q = in_q[SW-1] ? (~in_q + SW'(1)) : in_q;

  // running peak over both parts
  always_comb begin
    peak_in = peak_q;
    if (mag_i > peak_in) begin
      peak_in = mag_i;
    end
    if (mag_q > peak_in) begin
      peak_in = mag_q;
    end
  end

  assign s_axis_tready = (state_q == S_FILL);
  assign s_req         = s_axis_tvalid && s_axis_tready;
  assign win_full      = (cnt_q + CW'(1)) == CW'(WINDOW_DEPTH);
  assign win_close     = s_axis_tlast || win_full;

  // ---------------------------------------------------------------- output side
  assign m_axis_tvalid = (state_q == S_SEND);
  assign m_req         = m_axis_tvalid && m_axis_tready;
  assign last_res      = (CW'(idx_q) + CW'(1)) == cnt_q;
  assign m_axis_tlast  = last_res;
  assign m_axis_tdata  = OUT_W'({peak_q, out_q_q, out_i_q});

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FILL;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mem_wr    = 1'b0;
    mem_rd    = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      S_FILL: begin
        if (s_req) begin
          mem_wr = 1'b1;
          if (win_close) begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        mem_rd  = 1'b1;
        state_d = S_START_I;
      end
      S_START_I: begin
        div_start = 1'b1;
        state_d   = S_WAIT_I;
      end
      S_WAIT_I: begin
        if (div_done) begin
          state_d = S_START_Q;
        end
      end
      S_START_Q: begin
        div_start = 1'b1;
        state_d   = S_WAIT_Q;
      end
      S_WAIT_Q: begin
        if (div_done) begin
          state_d = S_SEND;
        end
      end
      S_SEND: begin
        if (m_req) begin
          state_d = last_res ? S_FILL : S_READ;
        end
      end
      default: begin
        state_d = S_FILL;
      end
    endcase
  end

  // count, peak and read pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      peak_q <= '0;
      idx_q  <= '0;
    end else if (mem_wr) begin
      cnt_q  <= cnt_q + CW'(1);
      peak_q <= peak_in;
      idx_q  <= '0;
    end else if (m_req) begin
      if (last_res) begin
        // window done, start the next one empty
        cnt_q  <= '0;
        peak_q <= '0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + AW'(1);
      end
    end
  end

  // store: one write port while filling, one registered read while emitting
  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      window_mem[cnt_q[AW-1:0]] <= {in_q, in_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_rd) begin
      rd_data_q <= window_mem[idx_q];
    end
  end

  // ---------------------------------------------------------------- shared divider
  assign div_x = (state_q == S_START_Q) ? rd_data_q[2*SW-1:SW] : rd_data_q[SW-1:0];

  wpnq_div #(
    .SW (SW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .x_i     (div_x),
    .peak_i  (peak_q),
    .exp_i   (div_exp),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // quantized level moved up into Q1.15
  always_ff @(posedge clk_i) begin
    if (div_done && (state_q == S_WAIT_I)) begin
      out_i_q <= div_quot <<< out_shift;
    end
    if (div_done && (state_q == S_WAIT_Q)) begin
      out_q_q <= div_quot <<< out_shift;
    end
  end

  // ---------------------------------------------------------------- checks
  `WPNQ_ASSERT_ALWAYS(a_no_overlap,
    !(s_axis_tready && m_axis_tvalid),
    "input and output overlap")
  `WPNQ_ASSERT_RUN(a_cnt_bound,
    cnt_q <= CW'(WINDOW_DEPTH),
    "fill count beyond store depth")
  `WPNQ_ASSERT_RUN(a_empty_peak,
    (cnt_q == '0) |-> (peak_q == '0),
    "peak held with empty window")
  `WPNQ_ASSERT_RUN(a_window_end,
    (m_req && m_axis_tlast) |=> (s_axis_tready && (cnt_q == '0)),
    "window not released after last result")

endmodule

`default_nettype wire
